@@ rtl/deq_pkg.sv @@
// Shared types and constants for the double-ended queue engine.
// Holds the request and response payloads, operation and status codes,
// controller state encoding and the controller/datapath interface structs.
package deq_pkg;

	localparam int DEQ_CAPACITY   = 16;
	localparam int DEQ_DATA_WIDTH = 32;

	typedef enum logic [2:0] {
		K_PUSH_FRONT = 3'd0,
		K_PUSH_BACK  = 3'd1,
		K_POP_FRONT  = 3'd2,
		K_POP_BACK   = 3'd3,
		K_PEEK_FRONT = 3'd4,
		K_PEEK_BACK  = 3'd5,
		K_SEARCH     = 3'd6,
		K_UPDATE     = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_MISS  = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] data_value;
		logic [3:0]         position;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] result_value;
		logic [3:0]         found_position;
		logic [4:0]         occupancy;
		logic               is_empty;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RDWAIT,
		S_SCAN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic scan_step;
		logic load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_popk;
		logic is_search;
		logic empty;
		logic hit;
		logic last;
		logic out_free;
	} dp_stat_t;

endpackage

@@ rtl/deq_ctrl.sv @@
// Controller state machine for the double-ended queue engine.
// Sequences capture, execute, read wait and search scan; depends on deq_pkg.
module deq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  deq_pkg::dp_stat_t   stat,
	output deq_pkg::ctrl_cmd_t  cmd
);

	deq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			deq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = deq_pkg::S_EXEC;
				end
			end
			deq_pkg::S_EXEC: begin
				// Nothing proceeds until the output register can take a result.
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					if (stat.is_popk && !stat.empty) begin
						state_d = deq_pkg::S_RDWAIT;
					end else if (stat.is_search && !stat.empty) begin
						state_d = deq_pkg::S_SCAN;
					end else begin
						cmd.load_out = 1'b1;
						state_d      = deq_pkg::S_IDLE;
					end
				end
			end
			deq_pkg::S_RDWAIT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = deq_pkg::S_IDLE;
				end
			end
			deq_pkg::S_SCAN: begin
				if (stat.out_free) begin
					if (stat.hit || stat.last) begin
						cmd.load_out = 1'b1;
						state_d      = deq_pkg::S_IDLE;
					end else begin
						cmd.scan_step = 1'b1;
					end
				end
			end
			default: begin
				state_d = deq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/deq_dp.sv @@
// Datapath for the double-ended queue engine: request latch, circular
// element memory, head pointer, count, scan index and output register.
// Depends on deq_pkg; driven by commands from deq_ctrl.
module deq_dp #(
	parameter int CAPACITY   = deq_pkg::DEQ_CAPACITY,
	parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  deq_pkg::req_t       req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output deq_pkg::rsp_t       rsp,
	input  deq_pkg::ctrl_cmd_t  cmd,
	output deq_pkg::dp_stat_t   stat
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// Slot of the element at an offset from the front; both inputs stay below
	// the capacity, so one conditional subtract wraps the sum.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (AW+1)'(CAPACITY)) begin
			sum = sum - (AW+1)'(CAPACITY);
		end
		return sum[AW-1:0];
	endfunction

	logic [DATA_WIDTH-1:0] mem [CAPACITY];

	deq_pkg::kind_t         kind_q;
	logic signed [31:0]     data_q;
	logic [3:0]             pos_q;
	logic [AW-1:0]          head_q, head_d;
	logic [CW-1:0]          count_q, count_d;
	logic [AW-1:0]          idx_q, idx_d;
	logic signed [DATA_WIDTH-1:0] rdata_q;
	logic                   out_valid_q;
	deq_pkg::rsp_t          rsp_q, rsp_d;

	logic                   we, re;
	logic [AW-1:0]          waddr, raddr;
	logic [DATA_WIDTH-1:0]  stored_in;
	logic signed [63:0]     data_wide, rdata_wide;
	logic [AW-1:0]          head_dec;
	logic                   full, empty, pos_ok, hit, last;

	assign data_wide  = 64'(data_q);
	assign stored_in  = data_wide[DATA_WIDTH-1:0];
	assign rdata_wide = 64'(rdata_q);

	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign pos_ok   = (int'(pos_q) < int'(count_q));
	assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
	assign hit      = (rdata_q == stored_in);
	assign last     = ((CW'(idx_q) + CW'(1)) == count_q);

	assign stat.is_popk   = (kind_q == deq_pkg::K_POP_FRONT) ||
		(kind_q == deq_pkg::K_POP_BACK) || (kind_q == deq_pkg::K_PEEK_FRONT) ||
		(kind_q == deq_pkg::K_PEEK_BACK);
	assign stat.is_search = (kind_q == deq_pkg::K_SEARCH);
	assign stat.empty     = empty;
	assign stat.hit       = hit;
	assign stat.last      = last;
	assign stat.out_free  = !out_valid_q || rsp_ready;

	always_comb begin
		we      = 1'b0;
		re      = 1'b0;
		waddr   = head_q;
		raddr   = head_q;
		head_d  = head_q;
		count_d = count_q;
		idx_d   = idx_q;
		if (cmd.exec) begin
			case (kind_q)
				deq_pkg::K_PUSH_FRONT: begin
					if (!full) begin
						we      = 1'b1;
						waddr   = head_dec;
						head_d  = head_dec;
						count_d = count_q + CW'(1);
					end
				end
				deq_pkg::K_PUSH_BACK: begin
					if (!full) begin
						we      = 1'b1;
						waddr   = slot_of(head_q, AW'(count_q));
						count_d = count_q + CW'(1);
					end
				end
				deq_pkg::K_POP_FRONT, deq_pkg::K_PEEK_FRONT: begin
					if (!empty) begin
						re    = 1'b1;
						raddr = head_q;
						if (kind_q == deq_pkg::K_POP_FRONT) begin
							head_d  = slot_of(head_q, AW'(1));
							count_d = count_q - CW'(1);
						end
					end
				end
				deq_pkg::K_POP_BACK, deq_pkg::K_PEEK_BACK: begin
					if (!empty) begin
						re    = 1'b1;
						raddr = slot_of(head_q, AW'(count_q - CW'(1)));
						if (kind_q == deq_pkg::K_POP_BACK) begin
							count_d = count_q - CW'(1);
						end
					end
				end
				deq_pkg::K_SEARCH: begin
					if (!empty) begin
						re    = 1'b1;
						raddr = head_q;
						idx_d = '0;
					end
				end
				deq_pkg::K_UPDATE: begin
					if (pos_ok) begin
						we    = 1'b1;
						waddr = slot_of(head_q, AW'(pos_q));
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.scan_step) begin
			// Fetch the next element while the index moves on to it.
			re    = 1'b1;
			raddr = slot_of(head_q, idx_q + AW'(1));
			idx_d = idx_q + AW'(1);
		end
	end

	always_comb begin
		rsp_d                = '0;
		rsp_d.occupancy      = 5'(count_d);
		rsp_d.is_empty       = (count_d == '0);
		if (cmd.exec) begin
			// Result decided in the execute cycle, without a memory read.
			case (kind_q)
				deq_pkg::K_PUSH_FRONT, deq_pkg::K_PUSH_BACK: begin
					rsp_d.status = full ? deq_pkg::ST_FULL : deq_pkg::ST_OK;
				end
				deq_pkg::K_SEARCH: begin
					rsp_d.status = deq_pkg::ST_MISS;
				end
				deq_pkg::K_UPDATE: begin
					rsp_d.status = pos_ok ? deq_pkg::ST_OK : deq_pkg::ST_MISS;
				end
				default: begin
					rsp_d.status = deq_pkg::ST_EMPTY;
				end
			endcase
		end else if (kind_q == deq_pkg::K_SEARCH) begin
			if (hit) begin
				rsp_d.status         = deq_pkg::ST_OK;
				rsp_d.found_position = 4'(idx_q);
			end else begin
				rsp_d.status = deq_pkg::ST_MISS;
			end
		end else begin
			rsp_d.status       = deq_pkg::ST_OK;
			rsp_d.result_value = rdata_wide[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= req.kind;
			data_q <= req.data_value;
			pos_q  <= req.position;
		end
		if (cmd.load_out) begin
			rsp_q <= rsp_d;
		end
		idx_q <= idx_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= stored_in;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/double_ended_queue_engine_unit.sv @@
// Top level of the double-ended queue engine: controller plus datapath.
// Depends on deq_pkg, deq_ctrl and deq_dp.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------
//   req     | in        | req_valid/req_ready  | deq_pkg::req_t
//   rsp     | out       | rsp_valid/rsp_ready  | deq_pkg::rsp_t
//
// One item is in work at a time; req_ready is high only while the controller idles.
// Push, update and failed requests finish in the execute state; pop and peek pass
// through a read wait state, set by the registered read port of the element memory.
// Search steps through the stored elements from the front until a match or the last one,
// one stored element compared per cycle while the output register is free.
// Reset clears head, count and the output valid; memory contents are not cleared.
// A stalled result holds the controller before it finishes the next item.
module double_ended_queue_engine_unit #(
	parameter int CAPACITY   = deq_pkg::DEQ_CAPACITY,
	parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  deq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output deq_pkg::rsp_t  rsp
);

	deq_pkg::ctrl_cmd_t cmd;
	deq_pkg::dp_stat_t  stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

	// An accepted item keeps the controller busy for at least the next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in work");

	// A result is only loaded when the output register is free.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded over a pending result");

	a_full_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == deq_pkg::ST_FULL) |-> rsp.occupancy == 5'(CAPACITY))
		else $error("refused push reports occupancy below capacity");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == deq_pkg::ST_EMPTY) |-> rsp.is_empty)
		else $error("empty status without empty flag");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue_engine_unit.
// Uses deq_pkg for the request/response payloads, kind codes and status codes.
// A directed table is followed by random traffic; every response is checked in order.
module tb_top;
	import deq_pkg::*;

	localparam int DEPTH        = DEQ_CAPACITY;
	localparam int RANDOM_ITEMS = 850;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 240;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  rsp_ready = 1'b0;
	req_t  req       = '0;
	logic  req_ready;
	logic  rsp_valid;
	rsp_t  rsp;

	double_ended_queue_engine_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the queue, advanced once per accepted request.
	logic [31:0] deq_mem [DEPTH];
	logic [3:0]  deq_head  = '0;
	logic [4:0]  deq_count = '0;

	rsp_t expected_rsp [$];
	int   mismatches    = 0;
	int   sent_items    = 0;
	int   results_seen  = 0;
	int   status_hits [4] = '{0, 0, 0, 0};
	int   peak_count    = 0;
	int   cycles        = 0;
	bit   no_gaps       = 1'b0;
	int   fill_mode     = 2;

	typedef struct {
		req_t r;
		int   reps;
		bit   fixed;
		rsp_t want;
	} step_t;

	step_t plan [$];

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_rsp.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic rsp_t apply_request(input req_t r);
		rsp_t       o;
		logic [3:0] slot;
		o = '0;
		o.status = ST_OK;
		case (r.kind)
			K_PUSH_FRONT, K_PUSH_BACK: begin
				if (deq_count == DEPTH) begin
					o.status = ST_FULL;
				end else if (r.kind == K_PUSH_FRONT) begin
					deq_head = deq_head - 4'd1;
					deq_mem[deq_head] = r.data_value;
					deq_count = deq_count + 5'd1;
				end else begin
					slot = deq_head + deq_count[3:0];
					deq_mem[slot] = r.data_value;
					deq_count = deq_count + 5'd1;
				end
			end
			K_POP_FRONT, K_PEEK_FRONT: begin
				if (deq_count == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.result_value = deq_mem[deq_head];
					if (r.kind == K_POP_FRONT) begin
						deq_head = deq_head + 4'd1;
						deq_count = deq_count - 5'd1;
					end
				end
			end
			K_POP_BACK, K_PEEK_BACK: begin
				if (deq_count == 0) begin
					o.status = ST_EMPTY;
				end else begin
					slot = deq_head + deq_count[3:0] - 4'd1;
					o.result_value = deq_mem[slot];
					if (r.kind == K_POP_BACK)
						deq_count = deq_count - 5'd1;
				end
			end
			K_SEARCH: begin
				o.status = ST_MISS;
				for (int i = 0; i < deq_count; i++) begin
					slot = deq_head + i[3:0];
					if (o.status == ST_MISS && deq_mem[slot] == r.data_value) begin
						o.status = ST_OK;
						o.found_position = i[3:0];
					end
				end
			end
			default: begin
				if ({1'b0, r.position} >= deq_count) begin
					o.status = ST_MISS;
				end else begin
					slot = deq_head + r.position;
					deq_mem[slot] = r.data_value;
				end
			end
		endcase
		o.occupancy = deq_count;
		o.is_empty  = (deq_count == 0);
		return o;
	endfunction

	function automatic rsp_t mk_rsp(input status_t s, input logic [31:0] v,
			input logic [3:0] f, input logic [4:0] occ);
		rsp_t o;
		o.status         = s;
		o.result_value   = v;
		o.found_position = f;
		o.occupancy      = occ;
		o.is_empty       = (occ == 0);
		return o;
	endfunction

	function automatic void add_step(input kind_t k, input logic [31:0] v, input logic [3:0] p,
			input int reps, input bit fixed, input rsp_t want);
		step_t s;
		s.r.kind       = k;
		s.r.data_value = v;
		s.r.position   = p;
		s.reps         = reps;
		s.fixed        = fixed;
		s.want         = want;
		plan.insert(plan.size(), s);
	endfunction

	function automatic int idle_draw();
		return no_gaps ? 0 : $urandom_range(0, 7);
	endfunction

	// Random requests lean toward filling or draining so the occupancy sweeps its range.
	function automatic req_t draw_request();
		req_t        r;
		int unsigned roll;
		int unsigned push_pct;
		int unsigned pop_pct;
		logic [3:0]  slot;
		push_pct = (fill_mode == 0) ? 60 : (fill_mode == 1) ? 15 : 35;
		pop_pct  = (fill_mode == 1) ? 50 : 20;
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			r.kind = $urandom_range(0, 1) ? K_PUSH_BACK : K_PUSH_FRONT;
		else if (roll < push_pct + pop_pct)
			r.kind = $urandom_range(0, 1) ? K_POP_BACK : K_POP_FRONT;
		else
			r.kind = kind_t'($urandom_range(4, 7));
		case ($urandom_range(0, 3))
			0: r.data_value = $urandom;
			1: begin
				case ($urandom_range(0, 7))
					0: r.data_value = 32'h0000_0000;
					1: r.data_value = 32'hFFFF_FFFF;
					2: r.data_value = 32'h8000_0000;
					3: r.data_value = 32'h7FFF_FFFF;
					4: r.data_value = 32'h0000_0001;
					5: r.data_value = 32'h5A5A_0000;
					6: r.data_value = 32'hFFFF_0000;
					default: r.data_value = 32'h0001_0000;
				endcase
			end
			2: begin
				// Reuse a value already held so searches hit at varied depths.
				if (deq_count != 0) begin
					slot = deq_head + 4'($urandom_range(0, deq_count - 1));
					r.data_value = deq_mem[slot];
				end else begin
					r.data_value = $urandom;
				end
			end
			default: r.data_value = $urandom;
		endcase
		if (r.kind == K_UPDATE && deq_count != 0 && $urandom_range(0, 3) != 0)
			r.position = 4'($urandom_range(0, deq_count - 1));
		else
			r.position = 4'($urandom_range(0, 15));
		return r;
	endfunction

	// Called at a rising edge; returns at the edge where the item is accepted.
	task automatic send_request(input req_t r, input bit fixed, input rsp_t want);
		int   gap;
		rsp_t predicted;
		gap = idle_draw();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(negedge clk); while (!req_ready);
		@(posedge clk);
		predicted = apply_request(r);
		expected_rsp.insert(expected_rsp.size(), fixed ? want : predicted);
		sent_items++;
		if (deq_count > peak_count)
			peak_count = deq_count;
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		results_seen++;
		status_hits[got.status]++;
		if (expected_rsp.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result %h", $time, got);
			return;
		end
		want = expected_rsp[0];
		expected_rsp.delete(0);
		if (got.status !== want.status) begin
			mismatches++;
			$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
		end
		if (got.result_value !== want.result_value) begin
			mismatches++;
			$display("%0t: result_value expected %h actual %h", $time,
				want.result_value, got.result_value);
		end
		if (got.found_position !== want.found_position) begin
			mismatches++;
			$display("%0t: found_position expected %0d actual %0d", $time,
				want.found_position, got.found_position);
		end
		if (got.occupancy !== want.occupancy) begin
			mismatches++;
			$display("%0t: occupancy expected %0d actual %0d", $time,
				want.occupancy, got.occupancy);
		end
		if (got.is_empty !== want.is_empty) begin
			mismatches++;
			$display("%0t: is_empty expected %0b actual %0b", $time,
				want.is_empty, got.is_empty);
		end
	endtask

	// Response side; one long hold-off lets the engine back up onto its input.
	initial begin : response_side
		int   gap;
		rsp_t got;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = (results_seen == HOLD_AT) ? HOLD_CYCLES : idle_draw();
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(negedge clk); while (!rsp_valid);
			got = rsp;
			@(posedge clk);
			check_result(got);
		end
	end

	initial begin : request_side
		req_t r;
		int   drain;
		// Empty queue: every read fails, search and update miss.
		add_step(K_POP_FRONT,  32'h0, 4'd0, 1, 1'b1, mk_rsp(ST_EMPTY, 32'h0, 4'd0, 5'd0));
		add_step(K_POP_BACK,   32'h0, 4'd0, 1, 1'b1, mk_rsp(ST_EMPTY, 32'h0, 4'd0, 5'd0));
		add_step(K_PEEK_FRONT, 32'h0, 4'd0, 1, 1'b1, mk_rsp(ST_EMPTY, 32'h0, 4'd0, 5'd0));
		add_step(K_PEEK_BACK,  32'h0, 4'd0, 1, 1'b1, mk_rsp(ST_EMPTY, 32'h0, 4'd0, 5'd0));
		add_step(K_SEARCH,     32'h0, 4'd0, 1, 1'b1, mk_rsp(ST_MISS,  32'h0, 4'd0, 5'd0));
		add_step(K_UPDATE,     32'h0, 4'd0, 1, 1'b1, mk_rsp(ST_MISS,  32'h0, 4'd0, 5'd0));
		// Extreme values at both ends; the front push wraps the head pointer.
		add_step(K_PUSH_BACK,  32'h7FFF_FFFF, 4'd0, 1, 1'b1, mk_rsp(ST_OK, 32'h0, 4'd0, 5'd1));
		add_step(K_PUSH_FRONT, 32'h8000_0000, 4'd0, 1, 1'b1, mk_rsp(ST_OK, 32'h0, 4'd0, 5'd2));
		add_step(K_PEEK_FRONT, 32'h0, 4'd0, 1, 1'b1,
			mk_rsp(ST_OK, 32'h8000_0000, 4'd0, 5'd2));
		add_step(K_PEEK_BACK,  32'h0, 4'd0, 1, 1'b1,
			mk_rsp(ST_OK, 32'h7FFF_FFFF, 4'd0, 5'd2));
		add_step(K_SEARCH,     32'h7FFF_FFFF, 4'd0, 1, 1'b1, mk_rsp(ST_OK, 32'h0, 4'd1, 5'd2));
		add_step(K_UPDATE,     32'hFFFF_FFFF, 4'd15, 1, 1'b1, mk_rsp(ST_MISS, 32'h0, 4'd0, 5'd2));
		add_step(K_UPDATE,     32'hFFFF_FFFF, 4'd1, 1, 1'b1, mk_rsp(ST_OK, 32'h0, 4'd0, 5'd2));
		// Fill to capacity, then pushes at either end are refused.
		add_step(K_PUSH_BACK,  32'h5A5A_0000, 4'd0, DEPTH - 2, 1'b0, '0);
		add_step(K_PUSH_FRONT, 32'h0000_0001, 4'd0, 1, 1'b1, mk_rsp(ST_FULL, 32'h0, 4'd0, 5'd16));
		add_step(K_PUSH_BACK,  32'h0000_0002, 4'd0, 1, 1'b1, mk_rsp(ST_FULL, 32'h0, 4'd0, 5'd16));
		add_step(K_SEARCH,     32'h0000_3039, 4'd0, 1, 1'b1, mk_rsp(ST_MISS, 32'h0, 4'd0, 5'd16));
		add_step(K_SEARCH,     32'h5A5A_0000, 4'd0, 1, 1'b0, '0);
		add_step(K_UPDATE,     32'h0000_0000, 4'd15, 1, 1'b0, '0);
		add_step(K_PEEK_BACK,  32'h0, 4'd0, 1, 1'b0, '0);
		add_step(K_POP_BACK,   32'h0, 4'd0, 1, 1'b0, '0);
		add_step(K_POP_FRONT,  32'h0, 4'd0, 1, 1'b0, '0);
		add_step(K_SEARCH,     32'hFFFF_FFFF, 4'd0, 1, 1'b0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			repeat (plan[i].reps)
				send_request(plan[i].r, plan[i].fixed, plan[i].want);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0) begin
				fill_mode = $urandom_range(0, 2);
				no_gaps   = ($urandom_range(0, 3) == 0);
			end
			r = draw_request();
			send_request(r, 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (expected_rsp.size() != 0)
			@(posedge clk);
		// Longest operation is a full search; allow a margin for stray results.
		drain = 4 * (DEPTH + 3);
		repeat (drain) @(posedge clk);

		$display("Sent %0d requests, %0d results; peak occupancy %0d.",
			sent_items, results_seen, peak_count);
		$display("Status mix: ok %0d, empty %0d, miss %0d, full %0d.",
			status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_MISS],
			status_hits[ST_FULL]);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
